### rtl/mrg_pkg.sv
// Package for the MRG-1597-2 random stream block.
// Holds recurrence multipliers, modulus, item mode codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package mrg_pkg;

    localparam int WORD_W    = 31;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int DEF_ORDER = 1597;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_word MOD_M31 = 31'h7FFF_FFFF;
    localparam t_word MUL_NEW = 31'd1057217510;
    localparam t_word MUL_OLD = 31'd1066409146;

    localparam t_mode MODE_RAW = 2'd0;
    localparam t_mode MODE_SAN = 2'd1;
    localparam t_mode MODE_GEN = 2'd2;

    typedef struct packed {
        logic       push;
        logic [1:0] count;
    } t_q_stat;

endpackage

### rtl/mrg_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read with read-before-write behavior on a shared address.
// No dependencies.
`timescale 1ns / 1ps

module mrg_ram #(
    parameter int W     = 31,
    parameter int DEPTH = 1597
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mrg_mulfold.sv
// Multiply stage and Mersenne fold for the recurrence step.
// Registers both products, then adds, folds at bit 31 and subtracts once.
// Depends on mrg_pkg.
`timescale 1ns / 1ps

module mrg_mulfold
    import mrg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_newest,
    input  t_word i_oldest,
    output t_word o_value
);

    t_prod                r_p_new;
    t_prod                r_p_old;
    logic [PROD_W:0]      sum;
    logic [WORD_W+1:0]    fold;
    logic [WORD_W+1:0]    fold_sub;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_new <= PROD_W'(i_newest) * PROD_W'(MUL_NEW);
            r_p_old <= PROD_W'(i_oldest) * PROD_W'(MUL_OLD);
        end
    end

    always_comb begin
        sum      = {1'b0, r_p_new} + {1'b0, r_p_old};
        fold     = (WORD_W+2)'(sum[WORD_W-1:0]) + (WORD_W+2)'(sum[PROD_W:WORD_W]);
        fold_sub = fold - (WORD_W+2)'(MOD_M31);
        o_value  = (fold >= (WORD_W+2)'(MOD_M31)) ? fold_sub[WORD_W-1:0]
                                                  : fold[WORD_W-1:0];
    end

endmodule

### rtl/mrg_outq.sv
// Two-entry result queue in front of the master-side stream.
// Reports its fill count so the input side can reserve a slot.
// Depends on mrg_pkg.
`timescale 1ns / 1ps

module mrg_outq
    import mrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output t_q_stat           o_stat,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata
);

    logic [DATA_W-1:0] r_d0;
    logic [DATA_W-1:0] r_d1;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              pop;

    assign pop   = (r_cnt != 2'd0) && i_tready;
    assign n_cnt = r_cnt + 2'(i_push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_d0 <= (r_cnt == 2'd2) ? r_d1 : i_data;
        end else if (r_cnt == 2'd0) begin
            r_d0 <= i_data;
        end
        if (i_push && (((r_cnt == 2'd1) && !pop) || ((r_cnt == 2'd2) && pop))) begin
            r_d1 <= i_data;
        end
    end

    assign o_tvalid     = (r_cnt != 2'd0);
    assign o_tdata      = r_d0;
    assign o_stat.push  = i_push;
    assign o_stat.count = r_cnt;

endmodule

### rtl/mrg_order1597_mod_mersenne31_prng.sv
// MRG-1597-2 random stream generator, modulus 2^31-1, top level.
// Uses mrg_pkg, mrg_ram (history), mrg_mulfold (arithmetic), mrg_outq (results).
//
// Usage:
//   Slave side carries items: tuser = mode, tdata = seed word. Mode raw or
//   sanitized load writes the next history entry and rearms generation;
//   mode generate yields one 32-bit result on the master side; mode three
//   is taken and dropped. Load all ORDER entries before the first generate.
//   A generate item's result passes the history read and multiply, then the
//   fold into the queue, and may then wait in the two-entry result queue.
//   Loads go at one item per cycle while tready is high; generates cannot:
//   the newest history word is the previous result, so the multiply and fold
//   loop sets the pace; tready drops for one cycle after each generate.
//   The oldest word comes from the history RAM, one read per generate, with
//   forwarding from the two writes that are still in flight.
//   Reset clears the pointers, the pipeline and the queue; the history RAM
//   keeps its contents and needs no clearing pass.
//   When the receiver stalls, results wait in the queue; tready drops once
//   the queue and the generate still in flight would fill it.
`timescale 1ns / 1ps

module mrg_order1597_mod_mersenne31_prng
    import mrg_pkg::*;
#(
    parameter int ORDER = DEF_ORDER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // [31:0] seed_word
    input  logic [MODE_W-1:0] i_s_axis_tuser,   // [1:0] mode
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata    // [31:0] random_value
);

    localparam int AW = $clog2(ORDER);
    localparam logic [AW-1:0] TOP_IDX = AW'(ORDER - 1);

    logic          r_oldest;
    logic [AW-1:0] r_old_idx;
    logic [AW-1:0] r_fill_idx;

    logic          r_s1_valid;
    logic          r_s1_gen;
    logic [AW-1:0] r_s1_addr;
    t_word         r_s1_data;

    logic          r_s2_valid;
    logic          r_s2_gen;
    logic [AW-1:0] r_s2_addr;
    t_word         r_s2_data;

    logic          r_wp_valid;
    logic [AW-1:0] r_wp_addr;
    t_word         r_wp_data;

    t_word         r_top;
    t_word         r_newest;

    logic          accept;
    logic          acc_load;
    logic          acc_gen;
    t_mode         mode;
    t_word         load_val;
    t_word         rd_data;
    t_word         old_fwd;
    t_word         newest_fwd;
    t_word         s2_load_newest;
    t_word         nv;
    t_word         wr_data;
    t_q_stat       q_stat;
    logic          s2_push;

    assign mode     = i_s_axis_tuser;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_load = accept && ((mode == MODE_RAW) || (mode == MODE_SAN));
    assign acc_gen  = accept && (mode == MODE_GEN);
    assign s2_push  = r_s2_valid && r_s2_gen;

    assign o_s_axis_tready = !(r_s1_valid && r_s1_gen) &&
                             ((q_stat.count == 2'd0) ||
                              ((q_stat.count == 2'd1) && !q_stat.push));

    always_comb begin
        load_val = i_s_axis_tdata[WORD_W-1:0];
        if ((mode == MODE_SAN) && ((load_val == '0) || (load_val == MOD_M31))) begin
            load_val = WORD_W'(1);
        end
    end

    // pointers update at acceptance; a load rewinds the oldest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_idx  <= '0;
            r_fill_idx <= '0;
            r_oldest   <= 1'b0;
        end else begin
            r_oldest <= 1'b0;
            if (acc_load) begin
                r_old_idx  <= '0;
                r_fill_idx <= (r_fill_idx == TOP_IDX) ? '0 : r_fill_idx + AW'(1);
            end else if (acc_gen) begin
                r_old_idx <= (r_old_idx == TOP_IDX) ? '0 : r_old_idx + AW'(1);
                r_oldest  <= 1'b1;
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_wp_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc_load || acc_gen;
            r_s2_valid <= r_s1_valid;
            r_wp_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_gen  <= acc_gen;
        r_s1_addr <= acc_gen ? r_old_idx : r_fill_idx;
        r_s1_data <= load_val;
        r_s2_gen  <= r_s1_gen;
        r_s2_addr <= r_s1_addr;
        r_s2_data <= r_s1_data;
        r_wp_addr <= r_s2_addr;
        r_wp_data <= wr_data;
    end

    mrg_ram #(
        .W     (WORD_W),
        .DEPTH (ORDER)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_addr),
        .i_wdata (wr_data),
        .i_raddr (r_old_idx),
        .o_rdata (rd_data)
    );

    // forward writes that missed the read
    always_comb begin
        if (r_s2_valid && !r_s2_gen && (r_s2_addr == r_s1_addr)) begin
            old_fwd = r_s2_data;
        end else if (r_wp_valid && (r_wp_addr == r_s1_addr)) begin
            old_fwd = r_wp_data;
        end else begin
            old_fwd = rd_data;
        end
        s2_load_newest = (r_s2_addr == TOP_IDX) ? r_s2_data : r_top;
        newest_fwd     = (r_s2_valid && !r_s2_gen) ? s2_load_newest : r_newest;
    end

    mrg_mulfold u_arith (
        .i_clk    (i_clk),
        .i_en     (r_s1_valid && r_s1_gen && r_oldest),
        .i_newest (newest_fwd),
        .i_oldest (old_fwd),
        .o_value  (nv)
    );

    assign wr_data = r_s2_gen ? nv : r_s2_data;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && (r_s2_addr == TOP_IDX)) begin
            r_top <= wr_data;
        end
        if (r_s2_valid) begin
            r_newest <= r_s2_gen ? nv : s2_load_newest;
        end
    end

    mrg_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s2_push),
        .i_data   ({nv, 1'b0}),
        .o_stat   (q_stat),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

### rtl/mrg_checker.sv
// Port-level checks for the MRG-1597-2 random stream block.
// Bound to mrg_order1597_mod_mersenne31_prng; depends on mrg_pkg.
`timescale 1ns / 1ps

module mrg_checker
    import mrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    input  logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,
    input  logic [MODE_W-1:0] i_s_axis_tuser,
    input  logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic [DATA_W-1:0] o_m_axis_tdata
);

    a_gen_pace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_GEN))
        |=> !o_s_axis_tready)
        else $error("ready high right after a generate item");

    a_lsb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[0] == 1'b0))
        else $error("result bit 0 set");

    a_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[DATA_W-1:1] != MOD_M31))
        else $error("result not reduced below modulus");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind mrg_order1597_mod_mersenne31_prng mrg_checker u_mrg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### dv/mrg_prng_scoreboard.sv
// Result scoreboard for the MRG-1597-2 random stream block.
// Watches both stream channels, keeps its own copy of the history ring and checks each draw.
// Depends on mrg_pkg for widths, multipliers, modulus and mode codes.
`timescale 1ns / 1ps

module mrg_prng_scoreboard
    import mrg_pkg::*;
#(
    parameter int ORDER = DEF_ORDER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [31:0] seed_word
    input  logic [MODE_W-1:0] i_s_tuser,   // [1:0] mode
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [DATA_W-1:0] i_m_tdata,   // [31:0] random_value
    output int                o_err_count,
    output int                o_pending,
    output int                o_checked
);

    t_word             ring [ORDER];
    int unsigned       oldest_ix;
    int unsigned       newest_ix;
    int unsigned       fill_ix;
    logic [DATA_W-1:0] expected_draws [$];
    int                err_count;
    int                checked;

    function automatic t_word fold_m31(bit [63:0] v);
        bit [63:0] s;
        s = {33'b0, v[30:0]} + (v >> 31);
        if (s >= 64'(MOD_M31))
            s = s - 64'(MOD_M31);
        return s[WORD_W-1:0];
    endfunction

    task automatic advance_ring(t_mode mode, logic [DATA_W-1:0] word);
        t_word     v;
        bit [63:0] sum;
        case (mode)
            MODE_RAW, MODE_SAN: begin
                v = word[WORD_W-1:0];
                if (mode == MODE_SAN && (v == '0 || v == MOD_M31))
                    v = WORD_W'(1);
                ring[fill_ix] = v;
                fill_ix       = (fill_ix + 1 >= ORDER) ? 0 : fill_ix + 1;
                oldest_ix     = 0;
                newest_ix     = ORDER - 1;
            end
            MODE_GEN: begin
                sum = 64'(MUL_NEW) * 64'(ring[newest_ix]) + 64'(MUL_OLD) * 64'(ring[oldest_ix]);
                v   = fold_m31(sum);
                ring[oldest_ix] = v;
                oldest_ix = (oldest_ix + 1 >= ORDER) ? 0 : oldest_ix + 1;
                newest_ix = (newest_ix + 1 >= ORDER) ? 0 : newest_ix + 1;
                expected_draws.push_back({v, 1'b0});
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            oldest_ix = 0;
            newest_ix = ORDER - 1;
            fill_ix   = 0;
            expected_draws.delete();
            err_count = 0;
            checked   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_draws.size() == 0) begin
                    $error("random_value: expected none, actual %h", i_m_tdata);
                    err_count++;
                end else begin
                    want = expected_draws.pop_front();
                    checked++;
                    if (i_m_tdata !== want) begin
                        $error("random_value: expected %h, actual %h", want, i_m_tdata);
                        err_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                advance_ring(i_s_tuser, i_s_tdata);
        end
        o_err_count <= err_count;
        o_pending   <= expected_draws.size();
        o_checked   <= checked;
    end

endmodule

### dv/mrg_order1597_mod_mersenne31_prng_tb.sv
// Testbench top for the MRG-1597-2 random stream block.
// Fills the history ring, then drives directed and random load, generate and no-op items with stalls.
// Depends on mrg_pkg, the block under test and mrg_prng_scoreboard.
`timescale 1ns / 1ps

module mrg_order1597_mod_mersenne31_prng_tb;
    import mrg_pkg::*;

    localparam int    ORDER       = DEF_ORDER;
    localparam t_mode MODE_NOP    = 2'd3;
    localparam int    HOLD_CYCLES = 300;
    localparam int    PURE_GENS   = 150;
    localparam int    MIXED_ITEMS = 100;
    localparam int    TAIL_ITEMS  = 40;
    localparam int    LIMIT_NS    = 5_000_000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [MODE_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              hold_req;
    logic              quiet_tail;
    bit                steady;
    int                err_count;
    int                pending;
    int                checked;
    int                n_raw;
    int                n_san;
    int                n_gen;
    int                n_nop;

    mrg_order1597_mod_mersenne31_prng #(
        .ORDER(ORDER)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    mrg_prng_scoreboard #(
        .ORDER(ORDER)
    ) u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] pick_seed_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic put_item(t_mode mode, logic [DATA_W-1:0] word);
        if (!steady && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
        case (mode)
            MODE_RAW: n_raw++;
            MODE_SAN: n_san++;
            MODE_GEN: n_gen++;
            default:  n_nop++;
        endcase
    endtask

    task automatic drain_draws();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial begin
        int pick;
        n_raw = 0;
        n_san = 0;
        n_gen = 0;
        n_nop = 0;
        steady = 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= MODE_NOP;
        hold_req   <= 1'b0;
        quiet_tail <= 1'b0;
        rst_n      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ORDER; i++) begin
            case (i)
                0:         put_item(MODE_RAW, 32'hFFFF_FFFF);
                1:         put_item(MODE_SAN, 32'h0000_0000);
                2:         put_item(MODE_SAN, 32'h7FFF_FFFF);
                3:         put_item(MODE_SAN, 32'hFFFF_FFFF);
                4:         put_item(MODE_RAW, 32'h8000_0000);
                5:         put_item(MODE_SAN, 32'h8000_0000);
                6:         put_item(MODE_RAW, 32'h0000_0000);
                ORDER - 1: put_item(MODE_RAW, 32'h7FFF_FFFF);
                default:   put_item($urandom_range(0, 1) ? MODE_SAN : MODE_RAW, pick_seed_word());
            endcase
        end

        put_item(MODE_NOP, 32'hFFFF_FFFF);
        put_item(MODE_GEN, 32'h0000_0000);
        put_item(MODE_GEN, 32'hFFFF_FFFF);
        repeat (8) put_item(MODE_GEN, $urandom);
        put_item(MODE_NOP, 32'h0000_0000);
        put_item(MODE_GEN, 32'hA5A5_5A5A);
        put_item(MODE_RAW, 32'h7FFF_FFFF);
        put_item(MODE_GEN, 32'h0000_0000);
        put_item(MODE_SAN, 32'h0000_0000);
        put_item(MODE_GEN, 32'hFFFF_FFFF);
        put_item(MODE_GEN, 32'h1234_5678);
        drain_draws();

        for (int i = 0; i < PURE_GENS; i++) begin
            if (i == 20) begin
                steady = 1'b1;
                hold_req <= 1'b1;
            end
            if (i == 60)
                steady = 1'b0;
            if ($urandom_range(0, 39) == 0)
                put_item(MODE_NOP, $urandom);
            else
                put_item(MODE_GEN, $urandom);
        end

        for (int i = 0; i < MIXED_ITEMS + TAIL_ITEMS; i++) begin
            if (i == MIXED_ITEMS / 2)
                drain_draws();
            if (i == MIXED_ITEMS)
                quiet_tail <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                put_item(MODE_GEN, $urandom);
            else if (pick < 80)
                put_item(MODE_RAW, pick_seed_word());
            else if (pick < 90)
                put_item(MODE_SAN, pick_seed_word());
            else
                put_item(MODE_NOP, $urandom);
        end

        drain_draws();
        repeat (20) @(posedge clk);

        $display("Run covered %0d raw loads, %0d sanitized loads, %0d generates, %0d no-op items.",
                 n_raw, n_san, n_gen, n_nop);
        $display("%0d draws checked across fill wrap, reloads and a %0d-cycle output stall.",
                 checked, HOLD_CYCLES);
        if (err_count == 0 && pending == 0)
            $display("mrg_order1597_mod_mersenne31_prng_tb: PASS");
        else
            $display("mrg_order1597_mod_mersenne31_prng_tb: FAIL");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout: %0d draws still pending.", pending);
        $display("mrg_order1597_mod_mersenne31_prng_tb: FAIL");
        $finish;
    end

endmodule

### mrg_order1597_mod_mersenne31_prng.f
rtl/mrg_pkg.sv
rtl/mrg_ram.sv
rtl/mrg_mulfold.sv
rtl/mrg_outq.sv
rtl/mrg_order1597_mod_mersenne31_prng.sv
rtl/mrg_checker.sv
dv/mrg_prng_scoreboard.sv
dv/mrg_order1597_mod_mersenne31_prng_tb.sv
